@@ hw/rtl/tlf_pkg.sv @@
package tlf_pkg;

   localparam int unsigned MAX_WIDTH_DEF = 63;
   // positions, counts and the width register all fit six bits (line width tops out at 63)
   localparam int unsigned POS_W         = 6;
   localparam int unsigned CMD_DEPTH     = 2;
   localparam int unsigned OUT_DEPTH     = 4;

   localparam logic [POS_W-1:0] LINE_WIDTH_RST = 6'd10;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;
   localparam logic [7:0] CH_SPACE   = 8'd32;

   typedef logic [POS_W-1:0] pos_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_stream;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_item_type;

   // emit len bytes from ring position start, then a newline
   typedef struct packed {
      pos_type start;
      pos_type len;
   } emit_cmd_type;

   typedef struct packed {
      logic       en;
      pos_type    addr;
      logic [7:0] data;
   } mem_wr_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_WAIT
   } front_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_RUN
   } back_state_type;

   // (a + b) mod depth, for a < depth and b <= depth
   function automatic pos_type ring_add(input pos_type a, input pos_type b,
                                        input pos_type depth);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, depth}) begin
         sum = sum - {1'b0, depth};
      end
      return sum[POS_W-1:0];
   endfunction

endpackage

@@ hw/rtl/tlf_fifo.sv @@
module tlf_fifo
   import tlf_pkg::*;
#(
   parameter type         item_type = logic [7:0],
   parameter int unsigned DEPTH     = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  item_type                     push_data,
   output logic                         full,
   input  logic                         pop,
   output item_type                     pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH+1);

   item_type             store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/tlf_front.sv @@
module tlf_front
   import tlf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_item_type  req_data,
   input  logic          csr_we,
   input  pos_type       csr_wdata,
   output logic          cmd_push,
   output emit_cmd_type  cmd_data,
   input  logic          back_idle,
   output mem_wr_type    mem_wr
);

   localparam pos_type DEPTH = POS_W'(MAX_WIDTH);

   front_state_type state_ff, state_in;
   pos_type         line_width_ff;
   pos_type         fill_ff, fill_in;
   pos_type         start_ff, start_in;
   logic            blank_ff, blank_in;
   pos_type         lbp_ff, lbp_in;
   mem_wr_type      pend_ff, pend_in;

   logic            accept;
   logic            emit;
   pos_type         width_eff;
   mem_wr_type      append;

   always_comb begin
      if (line_width_ff == '0) begin
         width_eff = POS_W'(1);
      end else if (line_width_ff > DEPTH) begin
         width_eff = DEPTH;
      end else begin
         width_eff = line_width_ff;
      end
   end

   // classify the item: what to emit, the new line state and the byte to append
   always_comb begin
      emit           = 1'b0;
      cmd_data.start = start_ff;
      cmd_data.len   = fill_ff;
      fill_in        = fill_ff;
      start_in       = start_ff;
      blank_in       = blank_ff;
      lbp_in         = lbp_ff;
      append.en      = 1'b0;
      append.addr    = '0;
      append.data    = req_data.text_byte;
      if (req_data.end_of_stream) begin
         emit     = (fill_ff != '0);
         fill_in  = '0;
         start_in = '0;
         blank_in = 1'b0;
         lbp_in   = '0;
      end else if (req_data.text_byte == CH_NEWLINE) begin
         emit     = 1'b1;
         fill_in  = '0;
         start_in = '0;
         blank_in = 1'b0;
         lbp_in   = '0;
      end else begin
         if (fill_ff >= width_eff) begin
            emit = 1'b1;
            if (blank_ff && (lbp_ff < fill_ff)) begin
               // fold at the last blank, drop it, keep the word after it
               cmd_data.len = lbp_ff;
               start_in     = ring_add(start_ff, pos_type'(lbp_ff + 1'b1), DEPTH);
               fill_in      = fill_ff - lbp_ff - 1'b1;
               blank_in     = 1'b0;
               lbp_in       = '0;
            end else begin
               fill_in  = '0;
               start_in = '0;
               blank_in = 1'b0;
               lbp_in   = '0;
            end
         end
         if (fill_in < DEPTH) begin
            append.en   = 1'b1;
            append.addr = ring_add(start_in, fill_in, DEPTH);
            if (req_data.text_byte == CH_SPACE || req_data.text_byte == CH_TAB) begin
               blank_in = 1'b1;
               lbp_in   = fill_in;
            end
            fill_in = fill_in + 1'b1;
         end
      end
   end

   // an item that emits holds its append until the back has read the old line
   always_comb begin
      state_in = state_ff;
      req_full = 1'b1;
      cmd_push = 1'b0;
      mem_wr   = '0;
      pend_in  = pend_ff;
      accept   = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            req_full = 1'b0;
            accept   = req_push;
            if (req_push) begin
               if (emit) begin
                  cmd_push = 1'b1;
                  pend_in  = append;
                  state_in = FRONT_WAIT;
               end else begin
                  mem_wr = append;
               end
            end
         end
         FRONT_WAIT: begin
            if (back_idle) begin
               mem_wr   = pend_ff;
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FRONT_IDLE;
         line_width_ff <= LINE_WIDTH_RST;
         fill_ff       <= '0;
         start_ff      <= '0;
         blank_ff      <= 1'b0;
         lbp_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            line_width_ff <= csr_wdata;
         end
         if (accept) begin
            fill_ff  <= fill_in;
            start_ff <= start_in;
            blank_ff <= blank_in;
            lbp_ff   <= lbp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

@@ hw/rtl/tlf_back.sv @@
module tlf_back
   import tlf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_empty,
   input  emit_cmd_type  cmd_data,
   output logic          cmd_pop,
   input  mem_wr_type    mem_wr,
   output logic          back_idle,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_item_type  rsp_data
);

   localparam pos_type     DEPTH  = POS_W'(MAX_WIDTH);
   localparam int unsigned ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned OCNT_W = $clog2(OUT_DEPTH+1);

   logic [7:0]      line_mem [MAX_WIDTH];
   logic [7:0]      rd_ff;

   back_state_type  state_ff, state_in;
   pos_type         ptr_ff, ptr_in;
   pos_type         left_ff, left_in;

   logic            stage_v_ff, stage_v_in;
   logic            stage_mem_ff, stage_mem_in;
   logic            stage_last_ff, stage_last_in;

   logic            rd_en;
   logic            credit;
   logic [OCNT_W-1:0] out_count;
   rsp_item_type    out_item;

   // room for the item in flight plus the one about to be read
   assign credit    = ({1'b0, out_count} + {{OCNT_W{1'b0}}, stage_v_ff})
                      < (OCNT_W+1)'(OUT_DEPTH);
   assign back_idle = (state_ff == BACK_IDLE) && cmd_empty;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      cmd_pop       = 1'b0;
      rd_en         = 1'b0;
      stage_v_in    = 1'b0;
      stage_mem_in  = 1'b0;
      stage_last_in = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               ptr_in   = cmd_data.start;
               left_in  = cmd_data.len;
               state_in = BACK_RUN;
            end
         end
         BACK_RUN: begin
            if (credit) begin
               stage_v_in = 1'b1;
               if (left_ff != '0) begin
                  rd_en        = 1'b1;
                  stage_mem_in = 1'b1;
                  ptr_in       = ring_add(ptr_ff, POS_W'(1), DEPTH);
                  left_in      = left_ff - 1'b1;
               end else begin
                  stage_last_in = 1'b1;
                  state_in      = BACK_IDLE;
               end
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BACK_IDLE;
         stage_v_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         stage_v_ff <= stage_v_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      stage_mem_ff  <= stage_mem_in;
      stage_last_ff <= stage_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr.en) begin
         line_mem[mem_wr.addr[ADDR_W-1:0]] <= mem_wr.data;
      end
      if (rd_en) begin
         rd_ff <= line_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   assign out_item.out_byte    = stage_mem_ff ? rd_ff : CH_NEWLINE;
   assign out_item.last_of_run = stage_last_ff;

   tlf_fifo #(
      .item_type (rsp_item_type),
      .DEPTH     (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (stage_v_ff),
      .push_data (out_item),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

endmodule

@@ hw/rtl/text_line_fold_at_blank.sv @@
// channel  | direction | handshake          | payload
// req_     | in        | req_push/req_full  | req_data  (text_byte, end_of_stream)
// rsp_     | out       | rsp_pop/rsp_empty  | rsp_data  (out_byte, last_of_run)
// csr_     | in        | csr_we             | csr_wdata (line_width)
//
// A byte that only appends is written to line memory as it is taken. An item
// emitting a line of n bytes yields n+1 result bytes from the line memory's single
// read port, one a cycle unless rsp_ stalls; the next item waits until that line is read.
// Synchronous active-high reset; line memory is not cleared. Stalls on rsp_
// back up through a four-item output queue to the line reader.
module text_line_fold_at_blank
   import tlf_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_item_type  req_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_item_type  rsp_data,
   input  logic          csr_we,
   input  pos_type       csr_wdata
);

   logic         cmd_push;
   emit_cmd_type cmd_in;
   logic         cmd_pop;
   emit_cmd_type cmd_out;
   logic         cmd_empty;
   logic         back_idle;
   mem_wr_type   mem_wr;

   tlf_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in),
      .back_idle (back_idle),
      .mem_wr    (mem_wr)
   );

   tlf_fifo #(
      .item_type (emit_cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty),
      .count     ()
   );

   tlf_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_out),
      .cmd_pop   (cmd_pop),
      .mem_wr    (mem_wr),
      .back_idle (back_idle),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
